>>> rtl/ftmd_pkg.sv
// Shared constants for the feature track motion detector.
`default_nettype none
package ftmd_pkg;
   localparam int MAX_FEATURES = 1024;
   localparam int IDX_W        = $clog2(MAX_FEATURES + 1);
   localparam int ADDR_W       = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int COORD_W      = 16;
   localparam int SQ_W         = 2 * COORD_W;
   localparam int ALU_W        = 35;
   localparam int ROOT_STEPS   = 17;
   localparam int ROOT_W       = 17;
   localparam int SUM_W        = 27;
   localparam int MEAN_W       = 17;
   localparam int THR_W        = 16;
   localparam int STEP_W       = 5;
   localparam int REM_W        = IDX_W;
   localparam logic [THR_W-1:0] THR_RESET = 16'd480;
endpackage
`default_nettype wire

>>> rtl/ftmd_ifs.sv
// Valid/ready channel interfaces for feature points and frame results.
`default_nettype none
interface ftmd_req_if;
   logic                            valid;
   logic                            ready;
   logic [ftmd_pkg::COORD_W-1:0]    point_x;
   logic [ftmd_pkg::COORD_W-1:0]    point_y;
   logic                            end_of_frame;
   logic                            end_of_sequence;
   modport source (output valid, point_x, point_y, end_of_frame, end_of_sequence,
                   input ready);
   modport sink (input valid, point_x, point_y, end_of_frame, end_of_sequence,
                 output ready);
endinterface

interface ftmd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ftmd_pkg::MEAN_W-1:0]     mean_distance;
   logic [ftmd_pkg::MEAN_W-1:0]     peak_mean_distance;
   logic                            verdict_ready;
   logic                            is_static;
   modport source (output valid, mean_distance, peak_mean_distance, verdict_ready,
                   is_static, input ready);
   modport sink (input valid, mean_distance, peak_mean_distance, verdict_ready,
                 is_static, output ready);
endinterface
`default_nettype wire

>>> rtl/feature_track_motion_detector.sv
// Top level: sequencer, reference store and result register of the motion detector.
//
// One feature point is handled at a time. A reference-frame point skips the distance
// steps; a compared point goes through RAM read, squaring of dx and dy on one 16x16
// multiplier, 17 root iterations on the shared compare-subtract unit, and accumulate.
// A point that ends a frame adds 27 divide iterations on the same unit (none if no
// reference point was used) and forms the result. A result waits in the output register
// until taken; the next frame result stalls the sequencer until that register is free.
// The reference store holds up to MAX_FEATURES points and needs no clearing after reset.
`default_nettype none
module feature_track_motion_detector (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ftmd_req_if.sink                           req_chan,
   ftmd_rsp_if.source                         rsp_chan,
   input  wire logic                          csr_wr_en,
   input  wire logic [ftmd_pkg::THR_W-1:0]    csr_wr_data
);
   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_SQX, S_SQY, S_ROOT, S_ACC, S_FRAME, S_DIV, S_RESULT
   } state_type;

   localparam int AW = ftmd_pkg::ADDR_W;
   localparam int IW = ftmd_pkg::IDX_W;
   localparam int CW = ftmd_pkg::COORD_W;
   localparam int XW = ftmd_pkg::ALU_W;
   localparam int SW = ftmd_pkg::SUM_W;
   localparam int MW = ftmd_pkg::MEAN_W;
   localparam int RW = ftmd_pkg::REM_W;
   localparam logic [IW-1:0] IDX_MAX   = IW'(ftmd_pkg::MAX_FEATURES);
   localparam logic [XW-1:0] BIT_START = XW'(1) << (2 * (ftmd_pkg::ROOT_STEPS - 1));

   state_type                   state_ff, state_in;
   logic [ftmd_pkg::THR_W-1:0]  thr_ff;
   logic [CW-1:0]               px_ff, py_ff, dx_ff, dy_ff;
   logic                        eof_ff, eos_ff;
   logic [IW-1:0]               idx_ff, ref_cnt_ff;
   logic [SW-1:0]               sum_ff, quot_ff;
   logic [MW-1:0]               peak_ff;
   logic                        first_ff, motion_ff;
   logic [XW-1:0]               v_ff, r_ff, bit_ff;
   logic [RW-1:0]               rem_ff;
   logic [IW-1:0]               div_ff;
   logic [ftmd_pkg::STEP_W-1:0] step_ff;
   logic                        rsp_valid_ff, verdict_ff, static_ff;
   logic [MW-1:0]               mean_out_ff, peak_out_ff;

   logic                        accept, idx_lt_max, do_store, do_read;
   logic [2*CW-1:0]             ram_rdata;
   logic [CW-1:0]               ref_x, ref_y, mul_in;
   logic [ftmd_pkg::SQ_W-1:0]   square;
   logic [XW-1:0]               alu_a, alu_b, alu_diff, r_plus_bit;
   logic                        alu_ge;
   logic [SW:0]                 sum_wide;
   logic [IW-1:0]               used;
   logic [MW-1:0]               mean, peak_new;
   logic                        exceed, motion_new, rsp_free, rsp_load;

   assign accept     = req_chan.valid && req_chan.ready;
   assign idx_lt_max = idx_ff < IDX_MAX;
   assign do_store   = accept && first_ff && idx_lt_max;
   assign do_read    = accept && !first_ff && idx_lt_max && (idx_ff < ref_cnt_ff);

   ftmd_ram #(.WIDTH(2 * CW), .DEPTH(ftmd_pkg::MAX_FEATURES)) u_ref_ram (
      .clock   (clock),
      .wr_en   (do_store),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data ({req_chan.point_x, req_chan.point_y}),
      .rd_en   (do_read),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   assign ref_x = ram_rdata[2*CW-1:CW];
   assign ref_y = ram_rdata[CW-1:0];

   assign mul_in     = (state_ff == S_SQX) ? dx_ff : dy_ff;
   assign square     = {{CW{1'b0}}, mul_in} * {{CW{1'b0}}, mul_in};
   assign r_plus_bit = r_ff + bit_ff;

   always_comb begin
      if (state_ff == S_DIV) begin
         alu_a = XW'({rem_ff, quot_ff[SW-1]});
         alu_b = XW'(div_ff);
      end else begin
         alu_a = v_ff;
         alu_b = r_plus_bit;
      end
   end

   ftmd_alu u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .diff (alu_diff),
      .ge   (alu_ge)
   );

   assign sum_wide   = {1'b0, sum_ff} + (SW + 1)'(r_ff[ftmd_pkg::ROOT_W-1:0]);
   assign used       = (idx_ff < ref_cnt_ff) ? idx_ff : ref_cnt_ff;
   assign mean       = (|quot_ff[SW-1:MW]) ? {MW{1'b1}} : quot_ff[MW-1:0];
   assign peak_new   = (mean > peak_ff) ? mean : peak_ff;
   assign exceed     = !motion_ff && (MW'(thr_ff) < mean);
   assign motion_new = motion_ff || exceed;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_load   = (state_ff == S_RESULT) && rsp_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (accept) state_in = do_read ? S_READ : S_FRAME;
         S_READ:   state_in = S_SQX;
         S_SQX:    state_in = S_SQY;
         S_SQY:    state_in = S_ROOT;
         S_ROOT:   if (step_ff == '0) state_in = S_ACC;
         S_ACC:    state_in = S_FRAME;
         S_FRAME: begin
            if (!eof_ff && !eos_ff) begin
               state_in = S_IDLE;
            end else if (used == '0) begin
               state_in = S_RESULT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV:    if (step_ff == '0) state_in = S_RESULT;
         S_RESULT: if (rsp_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         thr_ff       <= ftmd_pkg::THR_RESET;
         idx_ff       <= '0;
         ref_cnt_ff   <= '0;
         sum_ff       <= '0;
         peak_ff      <= '0;
         first_ff     <= 1'b1;
         motion_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            thr_ff <= csr_wr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  px_ff  <= req_chan.point_x;
                  py_ff  <= req_chan.point_y;
                  eof_ff <= req_chan.end_of_frame;
                  eos_ff <= req_chan.end_of_sequence;
                  if (idx_lt_max) begin
                     idx_ff <= idx_ff + IW'(1);
                  end
                  if (do_store) begin
                     ref_cnt_ff <= ref_cnt_ff + IW'(1);
                  end
               end
            end
            S_READ: begin
               dx_ff <= (px_ff >= ref_x) ? px_ff - ref_x : ref_x - px_ff;
               dy_ff <= (py_ff >= ref_y) ? py_ff - ref_y : ref_y - py_ff;
            end
            S_SQX: v_ff <= XW'(square);
            S_SQY: begin
               v_ff    <= v_ff + XW'(square);
               r_ff    <= '0;
               bit_ff  <= BIT_START;
               step_ff <= ftmd_pkg::STEP_W'(ftmd_pkg::ROOT_STEPS - 1);
            end
            S_ROOT: begin
               if (alu_ge) begin
                  v_ff <= alu_diff;
                  r_ff <= (r_ff >> 1) + bit_ff;
               end else begin
                  r_ff <= r_ff >> 1;
               end
               bit_ff  <= bit_ff >> 2;
               step_ff <= step_ff - ftmd_pkg::STEP_W'(1);
            end
            S_ACC: sum_ff <= sum_wide[SW] ? {SW{1'b1}} : sum_wide[SW-1:0];
            S_FRAME: begin
               rem_ff  <= '0;
               div_ff  <= used;
               step_ff <= ftmd_pkg::STEP_W'(SW - 1);
               quot_ff <= (used == '0) ? '0 : sum_ff;
            end
            S_DIV: begin
               rem_ff  <= alu_ge ? alu_diff[RW-1:0] : {rem_ff[RW-2:0], quot_ff[SW-1]};
               quot_ff <= {quot_ff[SW-2:0], alu_ge};
               step_ff <= step_ff - ftmd_pkg::STEP_W'(1);
            end
            S_RESULT: begin
               if (rsp_free) begin
                  mean_out_ff  <= mean;
                  peak_out_ff  <= peak_new;
                  verdict_ff   <= exceed || (eos_ff && !motion_new);
                  static_ff    <= !motion_new;
                  idx_ff       <= '0;
                  sum_ff       <= '0;
                  if (eos_ff) begin
                     ref_cnt_ff <= '0;
                     peak_ff    <= '0;
                     first_ff   <= 1'b1;
                     motion_ff  <= 1'b0;
                  end else begin
                     peak_ff    <= peak_new;
                     first_ff   <= 1'b0;
                     motion_ff  <= motion_new;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign req_chan.ready              = (state_ff == S_IDLE);
   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.mean_distance      = mean_out_ff;
   assign rsp_chan.peak_mean_distance = peak_out_ff;
   assign rsp_chan.verdict_ready      = verdict_ff;
   assign rsp_chan.is_static          = static_ff;
endmodule
`default_nettype wire

>>> rtl/ftmd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ftmd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                             wr_data,
   input  wire logic                                        rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> rtl/ftmd_alu.sv
// Shared compare-and-subtract unit for the root and divide iterations.
`default_nettype none
module ftmd_alu (
   input  wire logic [ftmd_pkg::ALU_W-1:0] op_a,
   input  wire logic [ftmd_pkg::ALU_W-1:0] op_b,
   output      logic [ftmd_pkg::ALU_W-1:0] diff,
   output      logic                       ge
);
   logic [ftmd_pkg::ALU_W:0] wide_diff;

   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign ge        = ~wide_diff[ftmd_pkg::ALU_W];
   assign diff      = wide_diff[ftmd_pkg::ALU_W-1:0];
endmodule
`default_nettype wire

>>> sim/feature_track_motion_detector_test.sv
// Self-checking testbench: random and directed feature tracks, scored against a frame-mean model.
module feature_track_motion_detector_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT   = 4000;
   localparam int DRAIN_CYCLES  = 64;
   localparam int PHASE_POINTS  = 130;
   localparam int MAX_REPORTS   = 40;
   localparam longint unsigned SUM_LIMIT  = (64'd1 << ftmd_pkg::SUM_W) - 64'd1;
   localparam longint unsigned MEAN_LIMIT = (64'd1 << ftmd_pkg::MEAN_W) - 64'd1;

   typedef enum {HOLD, JITTER, DRIFT, MIRROR, SCATTER} shift_mode_type;
   typedef enum {RX_STALLS_MORE, TX_GAPS_MORE, FULL_RATE} idle_plan_type;

   typedef struct packed {
      logic [ftmd_pkg::MEAN_W-1:0] mean;
      logic [ftmd_pkg::MEAN_W-1:0] peak;
      logic                        verdict;
      logic                        is_static;
   } frame_result_type;

   class motion_scoreboard;
      logic [ftmd_pkg::COORD_W-1:0] ref_x [ftmd_pkg::MAX_FEATURES];
      logic [ftmd_pkg::COORD_W-1:0] ref_y [ftmd_pkg::MAX_FEATURES];
      int unsigned                  ref_count;
      int unsigned                  pt_index;
      longint unsigned              dist_sum;
      longint unsigned              peak;
      bit                           first_frame;
      bit                           decided;
      logic [ftmd_pkg::THR_W-1:0]   threshold;
      frame_result_type             expected_results [$];
      int unsigned                  errors, reports, points, results, verdicts, motions;

      function new();
         threshold = ftmd_pkg::THR_RESET;
         errors    = 0;
         reports   = 0;
         points    = 0;
         results   = 0;
         verdicts  = 0;
         motions   = 0;
         clear_sequence();
      endfunction

      function void clear_sequence();
         ref_count   = 0;
         pt_index    = 0;
         dist_sum    = 0;
         peak        = 0;
         first_frame = 1'b1;
         decided     = 1'b0;
      endfunction

      function longint unsigned floor_root(longint unsigned v);
         longint unsigned root, probe;
         root  = 0;
         probe = 64'd1 << 34;
         while (probe > v)
            probe >>= 2;
         while (probe != 0) begin
            if (v >= root + probe) begin
               v    = v - (root + probe);
               root = (root >> 1) + probe;
            end else begin
               root >>= 1;
            end
            probe >>= 2;
         end
         return root;
      endfunction

      function void note_point(logic [ftmd_pkg::COORD_W-1:0] x,
                               logic [ftmd_pkg::COORD_W-1:0] y,
                               logic eof, logic eos);
         longint unsigned  dx, dy, used, mean;
         frame_result_type res;
         bit               verdict;
         points++;
         verdict = 1'b0;
         if (first_frame) begin
            if (pt_index < ftmd_pkg::MAX_FEATURES) begin
               ref_x[pt_index] = x;
               ref_y[pt_index] = y;
               ref_count++;
            end
         end else if (pt_index < ref_count && pt_index < ftmd_pkg::MAX_FEATURES) begin
            dx = (x >= ref_x[pt_index]) ? x - ref_x[pt_index] : ref_x[pt_index] - x;
            dy = (y >= ref_y[pt_index]) ? y - ref_y[pt_index] : ref_y[pt_index] - y;
            dist_sum += floor_root(dx * dx + dy * dy);
            if (dist_sum > SUM_LIMIT)
               dist_sum = SUM_LIMIT;
         end
         if (pt_index < ftmd_pkg::MAX_FEATURES)
            pt_index++;
         if (!eof && !eos)
            return;
         used = (pt_index < ref_count) ? pt_index : ref_count;
         mean = (used != 0) ? dist_sum / used : 0;
         if (mean > MEAN_LIMIT)
            mean = MEAN_LIMIT;
         if (mean > peak)
            peak = mean;
         if (!decided && mean > threshold) begin
            decided = 1'b1;
            verdict = 1'b1;
         end
         if (eos && !decided)
            verdict = 1'b1;
         res.mean      = mean[ftmd_pkg::MEAN_W-1:0];
         res.peak      = peak[ftmd_pkg::MEAN_W-1:0];
         res.verdict   = verdict;
         res.is_static = !decided;
         expected_results = {expected_results, res};
         first_frame = 1'b0;
         pt_index    = 0;
         dist_sum    = 0;
         if (eos)
            clear_sequence();
      endfunction

      function void compare_field(string name, logic [ftmd_pkg::MEAN_W-1:0] want,
                                  logic [ftmd_pkg::MEAN_W-1:0] got);
         if (want !== got) begin
            errors++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
         end
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         results++;
         if (expected_results.size() == 0) begin
            errors++;
            if (reports < MAX_REPORTS) begin
               reports++;
               $display("%0t: unexpected result, expected none, actual mean %0d peak %0d",
                        $time, got.mean, got.peak);
            end
            return;
         end
         want = expected_results.pop_front();
         if (want.verdict)
            verdicts++;
         if (want.verdict && !want.is_static)
            motions++;
         compare_field("mean_distance", want.mean, got.mean);
         compare_field("peak_mean_distance", want.peak, got.peak);
         compare_field("verdict_ready", want.verdict, got.verdict);
         compare_field("is_static", want.is_static, got.is_static);
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       csr_wr_en;
   logic [ftmd_pkg::THR_W-1:0] csr_wr_data;
   int unsigned      send_idle_pct = 19;
   int unsigned      recv_idle_pct = 54;
   int unsigned      points_sent   = 0;
   int unsigned      thresholds_used = 0;
   motion_scoreboard tracker = new();

   ftmd_req_if req_bus ();
   ftmd_rsp_if rsp_bus ();

   feature_track_motion_detector i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            tracker.note_point(req_bus.point_x, req_bus.point_y,
                               req_bus.end_of_frame, req_bus.end_of_sequence);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            tracker.check_result(frame_result_type'{rsp_bus.mean_distance,
                                                    rsp_bus.peak_mean_distance,
                                                    rsp_bus.verdict_ready,
                                                    rsp_bus.is_static});
      end
   end

   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic send_point(input logic [ftmd_pkg::COORD_W-1:0] x,
                             input logic [ftmd_pkg::COORD_W-1:0] y,
                             input logic eof, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.point_x         <= x;
      req_bus.point_y         <= y;
      req_bus.end_of_frame    <= eof;
      req_bus.end_of_sequence <= eos;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      points_sent++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (tracker.expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_threshold(input logic [ftmd_pkg::THR_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.threshold = value;
      thresholds_used++;
   endtask

   function automatic logic [ftmd_pkg::COORD_W-1:0] nudge(logic [ftmd_pkg::COORD_W-1:0] base,
                                                          int span);
      int v;
      v = int'(base) + int'($urandom_range(2 * span)) - span;
      if (v < 0)
         v = 0;
      if (v > 65535)
         v = 65535;
      return v[ftmd_pkg::COORD_W-1:0];
   endfunction

   task automatic send_sequence(input int unsigned ref_len, input bit noisy);
      logic [ftmd_pkg::COORD_W-1:0] ref_xs [$];
      logic [ftmd_pkg::COORD_W-1:0] ref_ys [$];
      logic [ftmd_pkg::COORD_W-1:0] x, y;
      int unsigned                  later, len, f, i;
      shift_mode_type               mode;
      bit                           corner, eof, eos, last;
      corner = ($urandom_range(3) == 0);
      later  = $urandom_range(4);
      for (f = 0; f <= later; f++) begin
         if (f == 0)
            len = ref_len;
         else if (ref_len <= 40 && $urandom_range(4) < 3)
            len = ref_len;
         else
            len = $urandom_range(1, (ref_len + 4 < 48) ? ref_len + 4 : 48);
         mode = shift_mode_type'($urandom_range(4));
         last = (f == later);
         for (i = 0; i < len; i++) begin
            if (f == 0) begin
               x = corner ? ($urandom_range(1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
               y = corner ? ($urandom_range(1) ? 16'hFFFF : 16'h0000) : 16'($urandom);
               ref_xs = {ref_xs, x};
               ref_ys = {ref_ys, y};
            end else if (i < ref_xs.size()) begin
               case (mode)
                  HOLD: begin
                     x = ref_xs[i];
                     y = ref_ys[i];
                  end
                  JITTER: begin
                     x = nudge(ref_xs[i], 15);
                     y = nudge(ref_ys[i], 15);
                  end
                  DRIFT: begin
                     x = nudge(ref_xs[i], 2047);
                     y = nudge(ref_ys[i], 2047);
                  end
                  MIRROR: begin
                     x = ~ref_xs[i];
                     y = ~ref_ys[i];
                  end
                  default: begin
                     x = 16'($urandom);
                     y = 16'($urandom);
                  end
               endcase
            end else begin
               x = 16'($urandom);
               y = 16'($urandom);
            end
            eof = (i == len - 1);
            eos = last && eof;
            if (eos && $urandom_range(9) < 3)
               eof = 1'b0;
            if (noisy) begin
               eof |= ($urandom_range(7) == 0);
               eos |= ($urandom_range(15) == 0);
            end
            send_point(x, y, eof, eos);
         end
      end
   endtask

   task automatic run_phase(input logic [ftmd_pkg::THR_W-1:0] thr, input idle_plan_type plan,
                            input bit with_long);
      int unsigned goal;
      case (plan)
         RX_STALLS_MORE: begin
            send_idle_pct = 19;
            recv_idle_pct = 54;
         end
         TX_GAPS_MORE: begin
            send_idle_pct = 54;
            recv_idle_pct = 19;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
      set_threshold(thr);
      if (with_long)
         send_sequence(ftmd_pkg::MAX_FEATURES + $urandom_range(1, 8), 1'b0);
      goal = points_sent + PHASE_POINTS;
      while (points_sent < goal)
         send_sequence(($urandom_range(6) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8),
                       $urandom_range(99) < 15);
      drain();
   endtask

   initial begin
      reset                   <= 1'b1;
      csr_wr_en               <= 1'b0;
      csr_wr_data             <= '0;
      req_bus.valid           <= 1'b0;
      req_bus.point_x         <= '0;
      req_bus.point_y         <= '0;
      req_bus.end_of_frame    <= 1'b0;
      req_bus.end_of_sequence <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // swap opposite corners, then report a frame after the verdict
      send_point(16'h0000, 16'h0000, 1'b0, 1'b0);
      send_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
      send_point(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
      send_point(16'h0000, 16'h0000, 1'b1, 1'b0);
      send_point(16'h0000, 16'h0000, 1'b0, 1'b0);
      send_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
      // short frame, long frame, close without frame end
      send_point(16'h0064, 16'h00C8, 1'b0, 1'b0);
      send_point(16'hFFFF, 16'h0000, 1'b0, 1'b0);
      send_point(16'h8000, 16'h7FFF, 1'b1, 1'b0);
      send_point(16'h0064, 16'h00C8, 1'b1, 1'b0);
      send_point(16'h0070, 16'h00C0, 1'b0, 1'b0);
      send_point(16'hFFF0, 16'h000F, 1'b0, 1'b0);
      send_point(16'h8005, 16'h7FFA, 1'b0, 1'b0);
      send_point(16'h5555, 16'hAAAA, 1'b0, 1'b0);
      send_point(16'hAAAA, 16'h5555, 1'b0, 1'b1);
      send_point(16'h1234, 16'h4321, 1'b1, 1'b1);
      // hit the threshold exactly, then step one above
      send_point(16'h0000, 16'h0000, 1'b1, 1'b0);
      send_point(ftmd_pkg::THR_RESET, 16'h0000, 1'b1, 1'b0);
      send_point(ftmd_pkg::THR_RESET + 16'd1, 16'h0000, 1'b1, 1'b1);
      drain();

      run_phase(16'h0000, RX_STALLS_MORE, 1'b0);
      run_phase(16'hFFFF, RX_STALLS_MORE, 1'b0);
      run_phase(ftmd_pkg::THR_W'($urandom_range(256, 4095)), TX_GAPS_MORE, 1'b0);
      run_phase(16'h0001, TX_GAPS_MORE, 1'b0);
      run_phase(ftmd_pkg::THR_W'($urandom), FULL_RATE, 1'b1);
      run_phase(ftmd_pkg::THR_RESET, FULL_RATE, 1'b0);

      if (tracker.expected_results.size() != 0) begin
         tracker.errors++;
         $display("%0t: results outstanding, expected 0, actual %0d", $time,
                  tracker.expected_results.size());
      end
      $display("Sent %0d feature points under %0d threshold settings and three idle plans.",
               tracker.points, thresholds_used);
      $display("Checked %0d frame results, %0d verdicts of which %0d found motion.",
               tracker.results, tracker.verdicts, tracker.motions);
      if (tracker.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
